FILE: rtl/fdsa_pkg.sv
// Package for the file directory and sector allocator.
// Sizes, command and status codes, store request/response structs, name match helper.
// No dependencies.
package fdsa_pkg;

  localparam int DIR_ENTRIES      = 16;
  localparam int SLOTS_PER_ENTRY  = 26;
  localparam int NUM_SECTORS      = 256;
  localparam int RESERVED_ENTRIES = 3;
  localparam int RESERVED_SECTORS = 3;

  localparam int NAME_W    = 48;
  localparam int NAME_BYTES = 6;
  localparam int ENTRY_W   = $clog2(DIR_ENTRIES);
  localparam int SLOT_DEPTH = DIR_ENTRIES * SLOTS_PER_ENTRY;
  localparam int SLOT_AW   = $clog2(SLOT_DEPTH);
  localparam int CNT_W     = $clog2(SLOTS_PER_ENTRY + 1);
  localparam int MAP_WORDS = NUM_SECTORS / 8;
  localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_CREATE = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_DIRFULL  = 2'd2;
  localparam logic [1:0] ST_NOSPACE  = 2'd3;

  typedef struct packed {
    logic               name_we;
    logic [ENTRY_W-1:0] name_waddr;
    logic [NAME_W-1:0]  name_wdata;
    logic               name_re;
    logic [ENTRY_W-1:0] name_raddr;
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    logic [7:0]         slot_wdata;
    logic               slot_re;
    logic [SLOT_AW-1:0] slot_raddr;
    logic               map_we;
    logic [MAP_AW-1:0]  map_waddr;
    logic [7:0]         map_wdata;
    logic               map_re;
    logic [MAP_AW-1:0]  map_raddr;
  } store_req_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [7:0]        slot;
    logic [7:0]        map;
  } store_rsp_t;

  // match up to and including the query's first zero byte
  function automatic logic prefix_match(input logic [NAME_W-1:0] stored,
                                        input logic [NAME_W-1:0] query);
    logic ok;
    logic done;
    ok   = 1'b1;
    done = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (!done) begin
        if (stored[8*i +: 8] != query[8*i +: 8]) begin
          ok   = 1'b0;
          done = 1'b1;
        end else if (query[8*i +: 8] == 8'h00) begin
          done = 1'b1;
        end
      end
    end
    return ok;
  endfunction

endpackage

FILE: rtl/fdsa_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module fdsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fdsa_store.sv
// Directory names, sector slot lists and sector-used map held in synchronous RAMs.
// Uses fdsa_pkg and fdsa_ram; per-row valid bits make unwritten name and map rows read as zero.
module fdsa_store (
  input  logic                clk,
  input  logic                rst,
  input  fdsa_pkg::store_req_t req,
  output fdsa_pkg::store_rsp_t rsp
);
  import fdsa_pkg::*;

  logic [DIR_ENTRIES-1:0] name_vld;
  logic [MAP_WORDS-1:0]   map_vld;
  logic                   name_rvld;
  logic                   map_rvld;
  logic [NAME_W-1:0]      name_raw;
  logic [7:0]             slot_raw;
  logic [7:0]             map_raw;

  fdsa_ram #(.WIDTH(NAME_W), .DEPTH(DIR_ENTRIES)) u_name (
    .clk(clk), .we(req.name_we), .waddr(req.name_waddr), .wdata(req.name_wdata),
    .re(req.name_re), .raddr(req.name_raddr), .rdata(name_raw)
  );

  fdsa_ram #(.WIDTH(8), .DEPTH(SLOT_DEPTH)) u_slot (
    .clk(clk), .we(req.slot_we), .waddr(req.slot_waddr), .wdata(req.slot_wdata),
    .re(req.slot_re), .raddr(req.slot_raddr), .rdata(slot_raw)
  );

  fdsa_ram #(.WIDTH(8), .DEPTH(MAP_WORDS)) u_map (
    .clk(clk), .we(req.map_we), .waddr(req.map_waddr), .wdata(req.map_wdata),
    .re(req.map_re), .raddr(req.map_raddr), .rdata(map_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      name_vld  <= '0;
      map_vld   <= '0;
      name_rvld <= 1'b0;
      map_rvld  <= 1'b0;
    end else begin
      if (req.name_re) name_rvld <= name_vld[req.name_raddr];
      if (req.map_re)  map_rvld  <= map_vld[req.map_raddr];
      if (req.name_we) name_vld[req.name_waddr] <= 1'b1;
      if (req.map_we)  map_vld[req.map_waddr]   <= 1'b1;
    end
  end

  assign rsp = '{name: (name_rvld ? name_raw : '0),
                 slot: slot_raw,
                 map:  (map_rvld ? map_raw : 8'h00)};

endmodule

FILE: rtl/file_directory_sector_allocator.sv
// Top level of the file directory and sector allocator: command sequencer and result register.
// Uses fdsa_pkg and fdsa_store.
//
// Usage: one command beat enters on the s_ group (tuser = command, tdata = name and
// sector count). s_tready is high only while no command is in progress.
// Each command yields one or more result beats on the m_ group, the final one with tlast.
// Lookup and create give one beat per sector in slot order, or one beat without a sector;
// a create that runs out of sectors ends with such a beat after its sector beats.
// Delete gives one beat. Command code 3 is dropped with no result. Each command first
// scans the directory one name at a time; lookup then reads each listed sector, create
// reads map words in turn and allocates from each free bit, and delete reads each listed
// sector and clears its map bit by read-modify-write.
// The result register holds a beat while m_tready is low; the sequencer waits for it.
// Reset clears the directory, slot counts and sector map at once through valid bits
// and fill counts; no clearing pass is needed and commands are taken right after reset.
module file_directory_sector_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // file_name[47:0], sector_count[52:48], zero pad
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // has_sector[0], sector[8:1], slot[13:9], zero pad
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);
  import fdsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_N_RD, S_N_CMP, S_L_RD, S_L_OUT, S_C_RD, S_C_LOAD, S_C_FIND,
    S_D_RD, S_D_SW, S_D_MW, S_FIN
  } state_t;

  state_t             state;
  logic [1:0]         cmd;
  logic [NAME_W-1:0]  qname;
  logic [CNT_W-1:0]   want;
  logic [ENTRY_W-1:0] e;
  logic [CNT_W-1:0]   s;
  logic [MAP_AW-1:0]  w;
  logic [7:0]         cur;
  logic [1:0]         fin_status;
  logic [CNT_W-1:0]   cnt [DIR_ENTRIES];

  logic [1:0]         out_status;
  logic               out_has;
  logic [7:0]         out_sector;
  logic [4:0]         out_slot;
  logic               out_last;

  store_req_t         req;
  store_rsp_t         rsp;

  logic               can_load;
  logic               out_load;
  logic               hit;
  logic [SLOT_AW-1:0] slot_addr;
  logic [7:0]         avail;
  logic [2:0]         pick;
  logic [7:0]         pick_bit;
  logic [7:0]         alloc_sec;
  logic [CNT_W-1:0]   s_inc;
  logic [CNT_W-1:0]   cnt_e;
  logic [4:0]         cnt_in;
  logic               del_in_map;
  logic [MAP_AW-1:0]  del_word;

  fdsa_store u_store (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign can_load   = !m_tvalid || m_tready;
  assign slot_addr  = SLOT_AW'(e) * SLOT_AW'(SLOTS_PER_ENTRY) + SLOT_AW'(s);
  assign s_inc      = s + 1'b1;
  assign cnt_e      = cnt[e];
  assign cnt_in     = s_tdata[52:48];
  assign del_in_map = {1'b0, rsp.slot} < 9'(NUM_SECTORS);
  assign del_word   = MAP_AW'(rsp.slot >> 3);
  // result register takes a new beat
  assign out_load   = can_load && ((state == S_L_OUT) || (state == S_FIN) ||
                                   (state == S_C_FIND && avail != 8'h00));

  always_comb begin
    priority case (cmd)
      CMD_LOOKUP: hit = prefix_match(rsp.name, qname);
      CMD_CREATE: hit = (rsp.name[7:0] == 8'h00);
      default:    hit = (rsp.name == qname);
    endcase
  end

  // free sectors in the current map word; sector 0 and the reserved low sectors never qualify
  always_comb begin
    logic [8:0] j;
    avail = '0;
    for (int i = 0; i < 8; i++) begin
      j = 9'(w) * 9'd8 + 9'(i);
      avail[i] = !cur[i] && (j >= 9'(RESERVED_SECTORS)) && (j != 9'd0)
                 && (j < 9'(NUM_SECTORS));
    end
    pick = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (avail[i]) pick = 3'(i);
    end
    pick_bit  = 8'd1 << pick;
    alloc_sec = 8'({w, pick});
  end

  always_comb begin
    req = '0;
    unique case (state)
      S_N_RD: begin
        req.name_re    = 1'b1;
        req.name_raddr = e;
      end
      S_N_CMP: begin
        if (hit && cmd == CMD_CREATE) begin
          req.name_we    = 1'b1;
          req.name_waddr = e;
          req.name_wdata = qname;
        end else if (hit && cmd == CMD_DELETE) begin
          req.name_we    = 1'b1;
          req.name_waddr = e;
          req.name_wdata = {rsp.name[NAME_W-1:8], 8'h00};
        end
      end
      S_L_RD, S_D_RD: begin
        req.slot_re    = 1'b1;
        req.slot_raddr = slot_addr;
      end
      S_C_RD: begin
        req.map_re    = 1'b1;
        req.map_raddr = w;
      end
      S_C_FIND: begin
        if (avail != 8'h00 && can_load) begin
          req.map_we     = 1'b1;
          req.map_waddr  = w;
          req.map_wdata  = cur | pick_bit;
          req.slot_we    = 1'b1;
          req.slot_waddr = slot_addr;
          req.slot_wdata = alloc_sec;
        end
      end
      S_D_SW: begin
        req.map_re    = del_in_map;
        req.map_raddr = del_word;
      end
      S_D_MW: begin
        req.map_we    = del_in_map;
        req.map_waddr = del_word;
        req.map_wdata = rsp.map & ~(8'd1 << rsp.slot[2:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < DIR_ENTRIES; i++) cnt[i] <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tuser != CMD_NONE) begin
            cmd   <= s_tuser;
            qname <= s_tdata[NAME_W-1:0];
            want  <= (cnt_in > 5'(SLOTS_PER_ENTRY)) ? CNT_W'(SLOTS_PER_ENTRY)
                                                     : CNT_W'(cnt_in);
            e     <= (s_tuser == CMD_CREATE) ? ENTRY_W'(RESERVED_ENTRIES) : '0;
            state <= S_N_RD;
          end
        end
        S_N_RD: state <= S_N_CMP;
        S_N_CMP: begin
          s          <= '0;
          fin_status <= ST_OK;
          if (hit) begin
            unique case (cmd)
              CMD_LOOKUP: state <= (cnt_e == '0) ? S_FIN : S_L_RD;
              CMD_CREATE: begin
                cnt[e] <= '0;
                w      <= MAP_AW'(RESERVED_SECTORS / 8);
                state  <= (want == '0) ? S_FIN : S_C_RD;
              end
              default:    state <= (cnt_e == '0) ? S_FIN : S_D_RD;
            endcase
          end else if (e == ENTRY_W'(DIR_ENTRIES - 1)) begin
            fin_status <= (cmd == CMD_CREATE) ? ST_DIRFULL : ST_NOTFOUND;
            state      <= S_FIN;
          end else begin
            e     <= e + 1'b1;
            state <= S_N_RD;
          end
        end
        S_L_RD: state <= S_L_OUT;
        S_L_OUT: begin
          if (can_load) begin
            out_status <= ST_OK;
            out_has    <= 1'b1;
            out_sector <= rsp.slot;
            out_slot   <= 5'(s);
            out_last   <= (s_inc == cnt_e);
            if (s_inc == cnt_e) begin
              state <= S_IDLE;
            end else begin
              s     <= s_inc;
              state <= S_L_RD;
            end
          end
        end
        S_C_RD: state <= S_C_LOAD;
        S_C_LOAD: begin
          cur   <= rsp.map;
          state <= S_C_FIND;
        end
        S_C_FIND: begin
          if (avail != 8'h00) begin
            if (can_load) begin
              out_status <= ST_OK;
              out_has    <= 1'b1;
              out_sector <= alloc_sec;
              out_slot   <= 5'(s);
              out_last   <= (s_inc == want);
              cnt[e]     <= s_inc;
              cur        <= cur | pick_bit;
              if (s_inc == want) begin
                state <= S_IDLE;
              end else begin
                s <= s_inc;
              end
            end
          end else if (w == MAP_AW'(MAP_WORDS - 1)) begin
            fin_status <= ST_NOSPACE;
            state      <= S_FIN;
          end else begin
            w     <= w + 1'b1;
            state <= S_C_RD;
          end
        end
        S_D_RD: state <= S_D_SW;
        S_D_SW: state <= S_D_MW;
        S_D_MW: begin
          if (s_inc == cnt_e) begin
            state <= S_FIN;
          end else begin
            s     <= s_inc;
            state <= S_D_RD;
          end
        end
        S_FIN: begin
          if (can_load) begin
            out_status <= fin_status;
            out_has    <= 1'b0;
            out_sector <= 8'h00;
            out_slot   <= 5'd0;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {2'b00, out_slot, out_sector, out_has};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  // a real command leaves idle at once
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser != CMD_NONE) |=> !s_tready)
    else $error("sequencer still idle after command beat");

  // an allocation never grows a list past its slot count
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (req.slot_we) |-> (cnt_e < CNT_W'(SLOTS_PER_ENTRY) && s < want))
    else $error("slot list overflow");

  // map writes only while allocating or freeing; this does not check slot writes
  a_map_wr_state: assert property (@(posedge clk) disable iff (rst)
    req.map_we |-> (state == S_C_FIND || state == S_D_MW))
    else $error("stray map write");

endmodule

FILE: tb/file_directory_sector_allocator_tb.sv
// Testbench for the file directory and sector allocator.
// Drives directed and random lookup/create/delete and unused-code beats, predicts every result beat.
// Depends on fdsa_pkg and file_directory_sector_allocator.
`timescale 1ns / 100ps

module file_directory_sector_allocator_tb;
  import fdsa_pkg::*;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] name;
    logic [4:0]  count;
  } cmd_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic       has;
    logic [7:0] sector;
    logic [4:0] slot;
    logic       last;
  } res_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  file_directory_sector_allocator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow directory
  logic [47:0] dir_name [DIR_ENTRIES];
  logic [7:0]  dir_sec  [DIR_ENTRIES][SLOTS_PER_ENTRY];
  logic        sec_used [NUM_SECTORS];

  cmd_beat_t pending_cmds[$];
  res_beat_t expected_res[$];
  int        mismatches = 0;
  bit        hold_off = 1'b0;
  logic [47:0] used_names[$];

  function automatic res_beat_t mk(logic [1:0] st, logic h, logic [7:0] sc, logic [4:0] sl,
                                   logic l);
    res_beat_t r;
    r.status = st; r.has = h; r.sector = sc; r.slot = sl; r.last = l;
    return r;
  endfunction

  function automatic bit name_prefix_eq(logic [47:0] stored, logic [47:0] q);
    for (int i = 0; i < 6; i++) begin
      if (stored[8*i +: 8] != q[8*i +: 8]) return 1'b0;
      if (q[8*i +: 8] == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic predict_command(cmd_beat_t c);
    int e, n, want, fs;
    n = 0;
    if (c.cmd == CMD_LOOKUP) begin
      for (e = 0; e < DIR_ENTRIES; e++) if (name_prefix_eq(dir_name[e], c.name)) break;
      if (e >= DIR_ENTRIES) begin
        expected_res.push_back(mk(ST_NOTFOUND, 0, 0, 0, 1));
        return;
      end
      for (int s = 0; s < SLOTS_PER_ENTRY; s++) begin
        if (dir_sec[e][s] == 0) break;
        expected_res.push_back(mk(ST_OK, 1, dir_sec[e][s], 5'(s), 0));
        n++;
      end
      if (n == 0) expected_res.push_back(mk(ST_OK, 0, 0, 0, 1));
      else expected_res[$].last = 1'b1;
    end else if (c.cmd == CMD_CREATE) begin
      for (e = RESERVED_ENTRIES; e < DIR_ENTRIES; e++) if (dir_name[e][7:0] == 0) break;
      if (e >= DIR_ENTRIES) begin
        expected_res.push_back(mk(ST_DIRFULL, 0, 0, 0, 1));
        return;
      end
      dir_name[e] = c.name;
      want = (c.count > SLOTS_PER_ENTRY) ? SLOTS_PER_ENTRY : int'(c.count);
      for (int s = 0; s < SLOTS_PER_ENTRY; s++) dir_sec[e][s] = 0;
      for (int s = 0; s < want; s++) begin
        fs = -1;
        for (int j = RESERVED_SECTORS; j < NUM_SECTORS; j++)
          if (j != 0 && !sec_used[j]) begin fs = j; break; end
        if (fs < 0) begin
          expected_res.push_back(mk(ST_NOSPACE, 0, 0, 0, 1));
          return;
        end
        sec_used[fs] = 1'b1;
        dir_sec[e][s] = 8'(fs);
        expected_res.push_back(mk(ST_OK, 1, 8'(fs), 5'(s), 0));
        n++;
      end
      if (n == 0) expected_res.push_back(mk(ST_OK, 0, 0, 0, 1));
      else expected_res[$].last = 1'b1;
    end else if (c.cmd == CMD_DELETE) begin
      for (e = 0; e < DIR_ENTRIES; e++) if (dir_name[e] == c.name) break;
      if (e >= DIR_ENTRIES) begin
        expected_res.push_back(mk(ST_NOTFOUND, 0, 0, 0, 1));
        return;
      end
      dir_name[e][7:0] = 8'h00;
      for (int s = 0; s < SLOTS_PER_ENTRY; s++) begin
        if (dir_sec[e][s] == 0) break;
        sec_used[dir_sec[e][s]] = 1'b0;
      end
      expected_res.push_back(mk(ST_OK, 0, 0, 0, 1));
    end
  endtask

  function automatic cmd_beat_t beat(logic [1:0] c, logic [47:0] n, logic [4:0] k);
    cmd_beat_t b;
    b.cmd = c; b.name = n; b.count = k;
    return b;
  endfunction

  function automatic logic [47:0] rand_name();
    logic [47:0] n;
    int len;
    n = 48'({$urandom, $urandom});
    len = $urandom_range(1, 6);
    for (int i = len; i < 6; i++) n[8*i +: 8] = 8'h00;
    if (n[7:0] == 0) n[7:0] = 8'h41;
    return n;
  endfunction

  // driver
  int        send_gap = 0;
  cmd_beat_t cur_cmd;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      predict_command(cur_cmd);
      s_tvalid <= 1'b0;
      send_gap <= $urandom_range(0, 14);
    end else if (!s_tvalid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_cmds.size() > 0 && !(hold_off && expected_res.size() > 0)) begin
        cur_cmd = pending_cmds.pop_front();
        s_tdata <= {3'b0, cur_cmd.count, cur_cmd.name};
        s_tuser <= cur_cmd.cmd;
        s_tvalid <= 1'b1;
      end
    end
  end

  // monitor
  int        recv_gap = 0;
  res_beat_t got, want_r;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = mk(m_tuser, m_tdata[0], m_tdata[8:1], m_tdata[13:9], m_tlast);
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          want_r = expected_res.pop_front();
          if (got !== want_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected st=%0d has=%0d sec=%0d slot=%0d last=%0d,",
                        " got st=%0d has=%0d sec=%0d slot=%0d last=%0d"},
                       want_r.status, want_r.has, want_r.sector, want_r.slot, want_r.last,
                       got.status, got.has, got.sector, got.slot, got.last);
          end
        end
        recv_gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [47:0] nm;
    int r;
    for (int e = 0; e < DIR_ENTRIES; e++) begin
      dir_name[e] = '0;
      for (int s = 0; s < SLOTS_PER_ENTRY; s++) dir_sec[e][s] = '0;
    end
    for (int j = 0; j < NUM_SECTORS; j++) sec_used[j] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty entry lookup, saturation, empty name, unused code, extremes
    pending_cmds.push_back(beat(CMD_LOOKUP, 48'h0, 0));
    pending_cmds.push_back(beat(CMD_LOOKUP, 48'h41, 0));
    pending_cmds.push_back(beat(CMD_DELETE, 48'h41, 0));
    pending_cmds.push_back(beat(CMD_CREATE, 48'hFFFF_FFFF_FFFF, 5'd31));
    pending_cmds.push_back(beat(CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 0));
    pending_cmds.push_back(beat(CMD_LOOKUP, 48'h0000_0000_FFFF, 0));
    pending_cmds.push_back(beat(CMD_CREATE, 48'h0000_0000_4241, 0));
    pending_cmds.push_back(beat(CMD_LOOKUP, 48'h0000_0000_4241, 0));
    pending_cmds.push_back(beat(CMD_NONE, 48'hFFFF_FFFF_FFFF, 5'd31));
    pending_cmds.push_back(beat(CMD_CREATE, 48'h0000_0000_6600, 3));
    pending_cmds.push_back(beat(CMD_LOOKUP, 48'h0, 0));
    pending_cmds.push_back(beat(CMD_DELETE, 48'hFFFF_FFFF_FFFF, 0));
    pending_cmds.push_back(beat(CMD_CREATE, 48'h0000_0000_0043, 26));
    pending_cmds.push_back(beat(CMD_LOOKUP, 48'h43, 0));
    // fill the disk: 13 entries x 26 sectors > 253 free
    for (int i = 0; i < 12; i++)
      pending_cmds.push_back(beat(CMD_CREATE, 48'h5000 + i + 48'h61, 26));
    wait (pending_cmds.size() == 0 && expected_res.size() == 0);
    repeat (200) @(posedge clk);

    // pause: sender waits for every expected result before each beat
    hold_off = 1'b1;
    pending_cmds.push_back(beat(CMD_LOOKUP, 48'h5061, 0));
    pending_cmds.push_back(beat(CMD_DELETE, 48'h0000_0000_0043, 0));
    pending_cmds.push_back(beat(CMD_DELETE, 48'h0000_0000_4241, 0));
    wait (pending_cmds.size() == 0 && expected_res.size() == 0);
    hold_off = 1'b0;

    for (int i = 0; i < 101; i++) begin
      r = $urandom_range(0, 19);
      if (used_names.size() > 0 && r < 12)
        nm = used_names[$urandom_range(0, used_names.size()-1)];
      else nm = rand_name();
      if (r == 19) nm = 48'({$urandom, $urandom});
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 3) == 0) nm[8*$urandom_range(1, 5) +: 8] = 8'h00;
          pending_cmds.push_back(beat(CMD_LOOKUP, nm, 5'($urandom)));
        end
        3, 4, 5: begin
          nm = rand_name();
          if ($urandom_range(0, 15) == 0) nm = 48'({$urandom, $urandom});
          used_names.push_back(nm);
          pending_cmds.push_back(beat(CMD_CREATE, nm,
                                      5'(($urandom_range(0, 7) == 0) ? $urandom
                                                                     : $urandom_range(0, 8))));
        end
        6, 7, 8: pending_cmds.push_back(beat(CMD_DELETE, nm, 5'($urandom)));
        default: pending_cmds.push_back(beat(2'($urandom), nm, 5'($urandom)));
      endcase
    end
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    wait (!s_tvalid);
    wait (expected_res.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_res.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
